>>> hw/rtl/i2a_pkg.sv
// Shared types, codes and character helpers for the integer to ASCII formatter.
// Used by the front end, the back end and the top level; depends on nothing else.
`default_nettype none

package i2a_pkg;

    // Fixed field widths of the two channels.
    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 64;
    localparam int CHAR_W   = 8;
    localparam int COUNT_W  = 5;

    // Format selector carried by each command item.
    typedef enum logic [1:0] {
        FMT_DEC  = 2'd0,
        FMT_HEXL = 2'd1,
        FMT_HEXU = 2'd2,
        FMT_PTR  = 2'd3
    } fmt_e;

    // Text written ahead of the digits.
    typedef enum logic [1:0] {
        PRE_NONE  = 2'd0,
        PRE_MINUS = 2'd1,
        PRE_HEX   = 2'd2,
        PRE_NIL   = 2'd3
    } pre_e;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_CONV = 2'd1,
        ST_PREP = 2'd2,
        ST_EMIT = 2'd3
    } back_state_e;

    // Command item payload.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [VALUE_W-1:0]  value;
    } cmd_t;

    // Character item payload.
    typedef struct packed {
        logic [CHAR_W-1:0]  out_char;
        logic               last;
        logic [COUNT_W-1:0] char_count;
    } chr_t;

    // Classification the front end attaches to each queued magnitude.
    typedef struct packed {
        pre_e pre;
        logic dec;
        logic upper;
    } entry_ctl_t;

    // ASCII for one decimal or hex digit.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] dw;
        dw = {4'h0, d};
        if (d < 4'd10)
            return dw + 8'h30;
        else if (upper)
            return dw + 8'h37;
        else
            return dw + 8'h57;
    endfunction

    // Number of prefix characters for each prefix kind.
    function automatic logic [COUNT_W-1:0] prefix_len(input pre_e pre);
        case (pre)
            PRE_NONE:  return 5'd0;
            PRE_MINUS: return 5'd1;
            PRE_HEX:   return 5'd2;
            PRE_NIL:   return 5'd5;
            default:   return 5'd0;
        endcase
    endfunction

    // Prefix character at a position within the prefix.
    function automatic logic [CHAR_W-1:0] prefix_char(input pre_e pre, input logic [2:0] idx);
        logic [CHAR_W-1:0] c;
        c = "0";
        case (pre)
            PRE_MINUS: c = "-";
            PRE_HEX:   c = (idx == 3'd0) ? "0" : "x";
            PRE_NIL:
            begin
                case (idx)
                    3'd0:    c = "(";
                    3'd1:    c = "n";
                    3'd2:    c = "i";
                    3'd3:    c = "l";
                    default: c = ")";
                endcase
            end
            default:   c = "0";
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter: front end, two-entry queue
// and back end. Depends on i2a_pkg, i2a_front, i2a_queue and i2a_back.
//
//   Channel  Direction  Handshake              Payload
//   cmd      in         cmd_valid / cmd_stall  cmd_t {action, value}
//   chr      out        chr_valid / chr_stall  chr_t {out_char, last, char_count}
//
// Hex and pointer items go from idle straight to the prep state and then emit their characters.
// Decimal items pass through the conversion state first; the shift-add-3 unit
// converts four operand bits per cycle.
// The two-entry queue keeps taking items while the back end works, until it is full.
// Reset is asynchronous, active low, and clears the queue, sequencer and output valid.
// A stalled character holds; the back end waits on it before the next one.
`default_nettype none

module integer_to_ascii_formatter
    import i2a_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_stall,
    input  wire cmd_t cmd,
    output logic      chr_valid,
    input  wire logic chr_stall,
    output chr_t      chr
);

    localparam int Q_W = $bits(entry_ctl_t) + VALUE_BITS;

    logic           q_full;
    logic           q_push;
    logic [Q_W-1:0] q_push_data;
    logic           q_pop;
    logic [Q_W-1:0] q_head;
    logic           q_head_valid;

    // Accept and classify.
    i2a_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_full    (q_full),
        .push      (q_push),
        .push_data (q_push_data)
    );

    // Decoupling queue.
    i2a_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_head_valid)
    );

    // Convert and emit.
    i2a_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .chr_valid  (chr_valid),
        .chr_stall  (chr_stall),
        .chr        (chr)
    );

`ifndef SYNTHESIS
    // The running count stays within the longest possible text.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        chr_valid |-> (chr.char_count != 5'd0) && (chr.char_count <= 5'd20))
        else $error("character count out of range");

    // Within one text, each character follows the previous one by one count.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(chr_valid && !chr_stall && !chr.last) && chr_valid)
            |-> (chr.char_count == $past(chr.char_count) + 5'd1))
        else $error("character count skipped within a text");

    // A new text always starts at count one.
    a_count_restart: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(chr_valid && !chr_stall && chr.last) && chr_valid)
            |-> (chr.char_count == 5'd1))
        else $error("text did not restart at count one");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/i2a_front.sv
// Front end: accepts command items, masks the operand, forms the magnitude
// and classifies the prefix. Depends on i2a_pkg.
`default_nettype none

module i2a_front
    import i2a_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                                     cmd_valid,
    output logic                                          cmd_stall,
    input  wire cmd_t                                     cmd,
    input  wire logic                                     q_full,
    output logic                                          push,
    output logic [$bits(entry_ctl_t)+VALUE_BITS-1:0]      push_data
);

    fmt_e                  fmt;
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] mag;
    logic                  neg;
    logic                  zero;
    entry_ctl_t            ctl;

    // The queue state alone decides whether an item can enter.
    assign cmd_stall = q_full;
    assign push      = cmd_valid && !q_full;

    // Mask the operand, take the magnitude and pick the prefix.
    always_comb
    begin
        fmt  = fmt_e'(cmd.action);
        v    = cmd.value[VALUE_BITS-1:0];
        zero = (v == '0);
        neg  = (fmt == FMT_DEC) && v[VALUE_BITS-1];
        mag  = neg ? (~v + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : v;

        ctl.dec   = (fmt == FMT_DEC);
        ctl.upper = (fmt == FMT_HEXU);
        if (neg)
            ctl.pre = PRE_MINUS;
        else if (fmt == FMT_PTR && zero)
            ctl.pre = PRE_NIL;
        else if (fmt == FMT_PTR)
            ctl.pre = PRE_HEX;
        else
            ctl.pre = PRE_NONE;

        push_data = {ctl, mag};
    end

endmodule

`default_nettype wire

>>> hw/rtl/i2a_queue.sv
// Two-entry queue that decouples the front end from the back end.
// Depends on nothing but the width it is given.
`default_nettype none

module i2a_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      head,
    output logic                  head_valid
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (!push && do_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

>>> hw/rtl/i2a_back.sv
// Back end: converts a queued magnitude to digits (shift-add-3 for decimal,
// nibbles for hex) and sends the text one character per item. Depends on i2a_pkg.
`default_nettype none

module i2a_back
    import i2a_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     head_valid,
    input  wire logic [$bits(entry_ctl_t)+VALUE_BITS-1:0] head,
    output logic                                          pop,
    output logic                                          chr_valid,
    input  wire logic                                     chr_stall,
    output chr_t                                          chr
);

    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int PAD_W      = 4 * HEX_DIGITS;
    localparam int DIG_N      = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int DIG_IDX_W  = $clog2(DIG_N);
    localparam int STEP_W     = $clog2(HEX_DIGITS + 1);

    back_state_e             state_reg;
    back_state_e             state_next;
    entry_ctl_t              ctl_reg;
    entry_ctl_t              ctl_next;
    logic [PAD_W-1:0]        bin_reg;
    logic [PAD_W-1:0]        bin_next;
    logic [DIG_N-1:0][3:0]   dig_reg;
    logic [DIG_N-1:0][3:0]   dig_next;
    logic [STEP_W-1:0]       step_reg;
    logic [STEP_W-1:0]       step_next;
    logic [COUNT_W-1:0]      len_reg;
    logic [COUNT_W-1:0]      len_next;
    logic [COUNT_W-1:0]      pos_reg;
    logic [COUNT_W-1:0]      pos_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    chr_t                    out_item_reg;
    chr_t                    out_item_next;

    entry_ctl_t              head_ctl;
    logic [PAD_W-1:0]        head_mag;
    logic [DIG_N-1:0][3:0]   dd_bcd;
    logic [PAD_W-1:0]        dd_bin;
    logic [COUNT_W-1:0]      top_cnt;
    logic [COUNT_W-1:0]      ndig;
    logic [COUNT_W-1:0]      pre_len;
    logic [COUNT_W-1:0]      dig_pos;
    logic                    load_ok;
    logic                    is_last;

    assign head_ctl  = entry_ctl_t'(head[$bits(entry_ctl_t)+VALUE_BITS-1:VALUE_BITS]);
    assign head_mag  = PAD_W'(head[VALUE_BITS-1:0]);
    assign chr_valid = out_valid_reg;
    assign chr       = out_item_reg;
    assign load_ok   = !out_valid_reg || !chr_stall;
    assign pre_len   = prefix_len(ctl_reg.pre);
    assign dig_pos   = len_reg - 5'd1 - pos_reg;
    assign is_last   = ((pos_reg + 5'd1) == len_reg);

    // Four shift-add-3 steps of the binary to BCD conversion.
    always_comb
    begin
        dd_bcd = dig_reg;
        dd_bin = bin_reg;
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < DIG_N; i++)
            begin
                if (dd_bcd[i] >= 4'd5)
                    dd_bcd[i] = dd_bcd[i] + 4'd3;
            end
            {dd_bcd, dd_bin} = {dd_bcd, dd_bin} << 1;
        end
    end

    // Position of the highest nonzero digit, and from it the digit count to emit (none for nil, one for zero).
    always_comb
    begin
        top_cnt = '0;
        for (int i = 0; i < DIG_N; i++)
        begin
            if (dig_reg[i] != 4'd0)
                top_cnt = COUNT_W'(i + 1);
        end
        if (ctl_reg.pre == PRE_NIL)
            ndig = '0;
        else if (top_cnt == '0)
            ndig = 5'd1;
        else
            ndig = top_cnt;
    end

    // Sequencer and output register.
    always_comb
    begin
        state_next     = state_reg;
        ctl_next       = ctl_reg;
        bin_next       = bin_reg;
        dig_next       = dig_reg;
        step_next      = step_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && chr_stall;
        out_item_next  = out_item_reg;
        pop            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop       = 1'b1;
                    ctl_next  = head_ctl;
                    pos_next  = '0;
                    step_next = '0;
                    if (head_ctl.dec)
                    begin
                        bin_next   = head_mag;
                        dig_next   = '0;
                        state_next = ST_CONV;
                    end
                    else
                    begin
                        dig_next = '0;
                        for (int i = 0; i < HEX_DIGITS; i++)
                            dig_next[i] = head_mag[4*i +: 4];
                        state_next = ST_PREP;
                    end
                end
            end
            ST_CONV:
            begin
                dig_next  = dd_bcd;
                bin_next  = dd_bin;
                step_next = step_reg + {{(STEP_W-1){1'b0}}, 1'b1};
                if (step_reg == STEP_W'(HEX_DIGITS - 1))
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                len_next   = pre_len + ndig;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load_ok)
                begin
                    out_valid_next           = 1'b1;
                    out_item_next.last       = is_last;
                    out_item_next.char_count = pos_reg + 5'd1;
                    if (pos_reg < pre_len)
                        out_item_next.out_char = prefix_char(ctl_reg.pre, pos_reg[2:0]);
                    else
                        out_item_next.out_char =
                            digit_char(dig_reg[dig_pos[DIG_IDX_W-1:0]], ctl_reg.upper);
                    pos_next = pos_reg + 5'd1;
                    if (is_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        ctl_reg      <= ctl_next;
        bin_reg      <= bin_next;
        dig_reg      <= dig_next;
        step_reg     <= step_next;
        len_reg      <= len_next;
        pos_reg      <= pos_next;
        out_item_reg <= out_item_next;
    end

endmodule

`default_nettype wire
